// ===== hw/rtl/iws_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iws_pkg
// Shared types and constants of the image warp sampler.
// ----------------------------------------------------------------------------
package iws_pkg;

    localparam int COORD_W   = 18;
    localparam int PIX_W     = 8;
    localparam int LOAD_W    = 9;
    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 2;
    localparam int NUM_BANKS = 4;

    localparam int DEF_MAX_WIDTH  = 512;
    localparam int DEF_MAX_HEIGHT = 512;
    localparam int DEF_FRAC_BITS  = 8;

    localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = CFG_W'(512);
    localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = CFG_W'(512);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INTERP_MODE  = 2'd0,
        CFG_FRAME_WIDTH  = 2'd1,
        CFG_FRAME_HEIGHT = 2'd2
    } t_cfg_reg;

    typedef enum logic {
        ACT_LOAD   = 1'b0,
        ACT_SAMPLE = 1'b1
    } t_action;

    typedef enum logic {
        INTERP_NEAREST  = 1'b0,
        INTERP_BILINEAR = 1'b1
    } t_interp;

    // per-sample control riding beside the bank reads
    // keep: a, b, c, d neighbor enables; x_odd / y_odd: parity of the base corner
    typedef struct packed {
        logic       valid;
        logic [3:0] keep;
        logic       x_odd;
        logic       y_odd;
    } t_tap_ctl;

endpackage

// ===== hw/rtl/iws_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iws_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module iws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/iws_coord.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iws_coord
// Input stage and bank addressing: splits map coordinates into integer
// corner and fraction weights, checks the frame bounds of the four
// neighbors and drives the four parity banks of the frame store.
// ----------------------------------------------------------------------------
module iws_coord
    import iws_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int FRAC_BITS  = DEF_FRAC_BITS,
    parameter int HCW        = 8,
    parameter int HRW        = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic                  i_action,
    input  logic [LOAD_W-1:0]     i_load_col,
    input  logic [LOAD_W-1:0]     i_load_row,
    input  logic [PIX_W-1:0]      i_load_pixel,
    input  logic [COORD_W-1:0]    i_map_x,
    input  logic [COORD_W-1:0]    i_map_y,
    input  logic                  i_interp_mode,
    input  logic [CFG_W-1:0]      i_frame_width,
    input  logic [CFG_W-1:0]      i_frame_height,
    output logic [NUM_BANKS-1:0]  o_bank_we,
    output logic [HRW+HCW-1:0]    o_waddr,
    output logic [PIX_W-1:0]      o_wdata,
    output logic                  o_re,
    output logic [HRW+HCW-1:0]    o_raddr [NUM_BANKS],
    output t_tap_ctl              o_ctl,
    output logic [FRAC_BITS-1:0]  o_wx,
    output logic [FRAC_BITS-1:0]  o_wy
);

    localparam int IW   = COORD_W + 1 - FRAC_BITS;
    localparam int XW   = IW + 1;
    localparam int DWW  = $clog2(MAX_WIDTH + 1);
    localparam int DWH  = $clog2(MAX_HEIGHT + 1);
    localparam int DW0  = (DWW > DWH) ? DWW : DWH;
    localparam int DW1  = (DW0 > CFG_W) ? DW0 : CFG_W;
    localparam int DW   = (DW1 > LOAD_W) ? DW1 : LOAD_W;
    localparam int CW   = ((XW > DW) ? XW : DW) + 1;
    localparam logic [COORD_W:0] HALF = (COORD_W + 1)'(1) << (FRAC_BITS - 1);

    logic                 r_vld;
    logic                 r_load;
    logic [LOAD_W-1:0]    r_lcol;
    logic [LOAD_W-1:0]    r_lrow;
    logic [PIX_W-1:0]     r_lpix;
    logic [CW-1:0]        r_bx;
    logic [CW-1:0]        r_by;
    logic [FRAC_BITS-1:0] r_wx;
    logic [FRAC_BITS-1:0] r_wy;
    logic                 r_neg;

    logic [CW-1:0]        n_bx;
    logic [CW-1:0]        n_by;
    logic [FRAC_BITS-1:0] n_wx;
    logic [FRAC_BITS-1:0] n_wy;
    logic [COORD_W:0]     xr;
    logic [COORD_W:0]     yr;

    t_tap_ctl             r_ctl;
    t_tap_ctl             n_ctl;
    logic [FRAC_BITS-1:0] r_wx2;
    logic [FRAC_BITS-1:0] r_wy2;

    logic [CW-1:0]        eff_w;
    logic [CW-1:0]        eff_h;
    logic [CW-1:0]        bx1;
    logic [CW-1:0]        by1;
    logic [CW-1:0]        col_even;
    logic [CW-1:0]        row_even;
    logic [CW-1:0]        lcol_x;
    logic [CW-1:0]        lrow_x;
    logic                 in_c0;
    logic                 in_c1;
    logic                 in_r0;
    logic                 in_r1;
    logic                 in_store;
    logic                 wx_nz;
    logic                 wy_nz;
    logic [HCW-1:0]       col_half [2];
    logic [HRW-1:0]       row_half [2];

    // corner and weights of the incoming sample
    always_comb begin
        xr = {i_map_x[COORD_W-1], i_map_x} + HALF;
        yr = {i_map_y[COORD_W-1], i_map_y} + HALF;
        if (t_interp'(i_interp_mode) == INTERP_NEAREST) begin
            n_bx = CW'(signed'(xr[COORD_W:FRAC_BITS]));
            n_by = CW'(signed'(yr[COORD_W:FRAC_BITS]));
            n_wx = '0;
            n_wy = '0;
        end else begin
            n_bx = CW'(signed'(i_map_x[COORD_W-1:FRAC_BITS]));
            n_by = CW'(signed'(i_map_y[COORD_W-1:FRAC_BITS]));
            n_wx = i_map_x[FRAC_BITS-1:0];
            n_wy = i_map_y[FRAC_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_load <= (t_action'(i_action) == ACT_LOAD);
        r_lcol <= i_load_col;
        r_lrow <= i_load_row;
        r_lpix <= i_load_pixel;
        r_bx   <= n_bx;
        r_by   <= n_by;
        r_wx   <= n_wx;
        r_wy   <= n_wy;
        r_neg  <= i_map_x[COORD_W-1];
    end

    // bounds and bank addressing
    always_comb begin
        eff_w = (CW'(i_frame_width) > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH)
                                                      : CW'(i_frame_width);
        eff_h = (CW'(i_frame_height) > CW'(MAX_HEIGHT)) ? CW'(MAX_HEIGHT)
                                                        : CW'(i_frame_height);
        bx1   = r_bx + CW'(1);
        by1   = r_by + CW'(1);
        in_c0 = !r_bx[CW-1] && (r_bx < eff_w);
        in_c1 = !bx1[CW-1] && (bx1 < eff_w);
        in_r0 = !r_by[CW-1] && (r_by < eff_h);
        in_r1 = !by1[CW-1] && (by1 < eff_h);
        wx_nz = (r_wx != '0);
        wy_nz = (r_wy != '0);

        col_even    = r_bx + CW'(r_bx[0]);
        row_even    = r_by + CW'(r_by[0]);
        col_half[0] = col_even[HCW:1];
        col_half[1] = r_bx[HCW:1];
        row_half[0] = row_even[HRW:1];
        row_half[1] = r_by[HRW:1];

        lcol_x   = CW'(r_lcol);
        lrow_x   = CW'(r_lrow);
        in_store = (lcol_x < CW'(MAX_WIDTH)) && (lrow_x < CW'(MAX_HEIGHT));

        n_ctl.valid   = r_vld && !r_load;
        n_ctl.keep[0] = !r_neg && in_c0 && in_r0;
        n_ctl.keep[1] = !r_neg && in_c1 && in_r0 && wx_nz;
        n_ctl.keep[2] = !r_neg && in_c0 && in_r1 && wy_nz;
        n_ctl.keep[3] = !r_neg && in_c1 && in_r1 && wx_nz && wy_nz;
        n_ctl.x_odd   = r_bx[0];
        n_ctl.y_odd   = r_by[0];
    end

    always_comb begin
        for (int k = 0; k < NUM_BANKS; k++) begin
            o_bank_we[k] = r_vld && r_load && in_store
                           && (r_lrow[0] == k[1]) && (r_lcol[0] == k[0]);
            o_raddr[k]   = {row_half[k[1]], col_half[k[0]]};
        end
    end

    assign o_waddr = {lrow_x[HRW:1], lcol_x[HCW:1]};
    assign o_wdata = r_lpix;
    assign o_re    = r_vld && !r_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else begin
            r_ctl.valid <= n_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ctl.keep  <= n_ctl.keep;
        r_ctl.x_odd <= n_ctl.x_odd;
        r_ctl.y_odd <= n_ctl.y_odd;
        r_wx2       <= r_wx;
        r_wy2       <= r_wy;
    end

    assign o_ctl = r_ctl;
    assign o_wx  = r_wx2;
    assign o_wy  = r_wy2;

endmodule

// ===== hw/rtl/iws_blend.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iws_blend
// Weighting datapath: picks the four neighbors out of the parity banks,
// blends vertically, then horizontally, and registers the result pixel.
// ----------------------------------------------------------------------------
module iws_blend
    import iws_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_tap_ctl             i_ctl,
    input  logic [FRAC_BITS-1:0] i_wx,
    input  logic [FRAC_BITS-1:0] i_wy,
    input  logic [PIX_W-1:0]     i_bank_data [NUM_BANKS],
    output logic                 o_valid,
    output logic [PIX_W-1:0]     o_pixel
);

    localparam int SW  = FRAC_BITS + 1;
    localparam int LW  = PIX_W + FRAC_BITS;
    localparam int AW  = PIX_W + 2 * FRAC_BITS;
    localparam logic [SW-1:0] ONE = SW'(1) << FRAC_BITS;

    logic [PIX_W-1:0] nb [4];
    logic [SW-1:0]    wy_inv;
    logic [LW-1:0]    n_left;
    logic [LW-1:0]    n_right;
    logic [1:0]       sel [4];

    logic             r_vld3;
    logic [LW-1:0]    r_left;
    logic [LW-1:0]    r_right;
    logic [SW-1:0]    r_wx;

    logic [SW-1:0]    wx_inv;
    logic [AW-1:0]    n_acc;

    logic             r_vld4;
    logic [PIX_W-1:0] r_pixel;

    // neighbor order a, b, c, d; bank index is {row parity, col parity}
    always_comb begin
        sel[0] = {i_ctl.y_odd, i_ctl.x_odd};
        sel[1] = {i_ctl.y_odd, !i_ctl.x_odd};
        sel[2] = {!i_ctl.y_odd, i_ctl.x_odd};
        sel[3] = {!i_ctl.y_odd, !i_ctl.x_odd};
        for (int k = 0; k < 4; k++) begin
            nb[k] = i_ctl.keep[k] ? i_bank_data[sel[k]] : '0;
        end
        wy_inv  = ONE - SW'(i_wy);
        n_left  = LW'(wy_inv) * LW'(nb[0]) + LW'(i_wy) * LW'(nb[2]);
        n_right = LW'(wy_inv) * LW'(nb[1]) + LW'(i_wy) * LW'(nb[3]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld3 <= 1'b0;
        end else begin
            r_vld3 <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_left  <= n_left;
        r_right <= n_right;
        r_wx    <= SW'(i_wx);
    end

    always_comb begin
        wx_inv = ONE - r_wx;
        n_acc  = AW'(wx_inv) * AW'(r_left) + AW'(r_wx) * AW'(r_right);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld4 <= 1'b0;
        end else begin
            r_vld4 <= r_vld3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pixel <= n_acc[2*FRAC_BITS +: PIX_W];
    end

    assign o_valid = r_vld4;
    assign o_pixel = r_pixel;

endmodule

// ===== hw/rtl/image_warp_sampler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_warp_sampler
// Bilinear / nearest-neighbor remap sampler over an 8-bit frame store.
//
// Usage: drive a word on the input ports with start high; it is taken at
// every clock edge where start is high and busy is low. busy stays low, so
// one word enters per cycle. A load word (action 0) writes one source pixel
// and returns nothing. A sample word (action 1) returns one pixel on
// o_pixel_out, marked by o_valid for one cycle, after the input, bank read,
// blend and output registers, in input order. The receiver cannot stall.
// Throughput is one word per cycle: the frame store is split into four
// banks by row and column parity, so all four neighbors of a sample are
// read in the same cycle. A load is seen by every sample taken after it.
// Configuration (mode, frame width, frame height) is written through
// i_cfg_we / i_cfg_idx / i_cfg_wdata while no word is in flight.
// Reset restores bilinear mode and a 512 x 512 frame; the frame store is
// not cleared, and a pixel must be loaded before it is sampled.
// ----------------------------------------------------------------------------
module image_warp_sampler
    import iws_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_action,
    input  logic [LOAD_W-1:0]    i_load_col,
    input  logic [LOAD_W-1:0]    i_load_row,
    input  logic [PIX_W-1:0]     i_load_pixel,
    input  logic [COORD_W-1:0]   i_map_x,
    input  logic [COORD_W-1:0]   i_map_y,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    output logic                 o_valid,
    output logic [PIX_W-1:0]     o_pixel_out
);

    localparam int HCW0 = $clog2((MAX_WIDTH + 1) / 2);
    localparam int HRW0 = $clog2((MAX_HEIGHT + 1) / 2);
    localparam int HCW  = (HCW0 > 0) ? HCW0 : 1;
    localparam int HRW  = (HRW0 > 0) ? HRW0 : 1;
    localparam int BANK_DEPTH = 1 << (HCW + HRW);

    logic             r_interp_mode;
    logic [CFG_W-1:0] r_frame_width;
    logic [CFG_W-1:0] r_frame_height;

    logic                   accept;
    logic [NUM_BANKS-1:0]   bank_we;
    logic [HRW+HCW-1:0]     waddr;
    logic [PIX_W-1:0]       wdata;
    logic                   re;
    logic [HRW+HCW-1:0]     raddr [NUM_BANKS];
    logic [PIX_W-1:0]       rdata [NUM_BANKS];
    t_tap_ctl               ctl;
    logic [FRAC_BITS-1:0]   wx;
    logic [FRAC_BITS-1:0]   wy;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interp_mode  <= INTERP_BILINEAR;
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                CFG_INTERP_MODE:  r_interp_mode  <= i_cfg_wdata[0];
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_wdata;
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    iws_coord #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .FRAC_BITS  (FRAC_BITS),
        .HCW        (HCW),
        .HRW        (HRW)
    ) u_coord (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_action       (i_action),
        .i_load_col     (i_load_col),
        .i_load_row     (i_load_row),
        .i_load_pixel   (i_load_pixel),
        .i_map_x        (i_map_x),
        .i_map_y        (i_map_y),
        .i_interp_mode  (r_interp_mode),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .o_bank_we      (bank_we),
        .o_waddr        (waddr),
        .o_wdata        (wdata),
        .o_re           (re),
        .o_raddr        (raddr),
        .o_ctl          (ctl),
        .o_wx           (wx),
        .o_wy           (wy)
    );

    for (genvar k = 0; k < NUM_BANKS; k++) begin : g_bank
        iws_ram #(
            .WIDTH (PIX_W),
            .DEPTH (BANK_DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (bank_we[k]),
            .i_waddr (waddr),
            .i_wdata (wdata),
            .i_re    (re),
            .i_raddr (raddr[k]),
            .o_rdata (rdata[k])
        );
    end

    iws_blend #(
        .FRAC_BITS (FRAC_BITS)
    ) u_blend (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_wx        (wx),
        .i_wy        (wy),
        .i_bank_data (rdata),
        .o_valid     (o_valid),
        .o_pixel     (o_pixel_out)
    );

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the image warp sampler.
//
// Pixel loads and sample words go in through the start/busy port. A local
// copy of the frame store, mode and frame size predicts every sampled pixel,
// in both nearest and bilinear modes. Each o_valid beat is checked in order
// against the queue of predicted pixels. A few directed words cover the
// coordinate extremes, rounding and the frame edges. Random phases follow,
// each under its own mode and frame size, zero and oversized frames among
// them. Samples are kept to pixels that were loaded or that lie outside the
// frame.
// ----------------------------------------------------------------------------
module tb_top;
    import iws_pkg::*;

    localparam int MAXW        = DEF_MAX_WIDTH;
    localparam int MAXH        = DEF_MAX_HEIGHT;
    localparam int FRAC        = DEF_FRAC_BITS;
    localparam int ONE         = 1 << FRAC;
    localparam int LATENCY     = 4;
    localparam int NUM_PHASES  = 14;
    localparam int PHASE_WORDS = 90;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [PIX_W-1:0]   pixel;
        logic [COORD_W-1:0] mx;
        logic [COORD_W-1:0] my;
    } t_pixel_expect;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic                 i_action;
    logic [LOAD_W-1:0]    i_load_col;
    logic [LOAD_W-1:0]    i_load_row;
    logic [PIX_W-1:0]     i_load_pixel;
    logic [COORD_W-1:0]   i_map_x;
    logic [COORD_W-1:0]   i_map_y;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_wdata;
    logic                 o_valid;
    logic [PIX_W-1:0]     o_pixel_out;

    logic [PIX_W-1:0] frame_copy   [MAXW*MAXH];
    bit               frame_loaded [MAXW*MAXH];
    t_interp          sim_mode;
    logic [CFG_W-1:0] sim_w;
    logic [CFG_W-1:0] sim_h;

    t_pixel_expect expected_pixels[$];
    t_pixel_expect oldest;
    int            mismatch_cnt = 0;
    int            cycle_cnt = 0;

    image_warp_sampler u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_action     (i_action),
        .i_load_col   (i_load_col),
        .i_load_row   (i_load_row),
        .i_load_pixel (i_load_pixel),
        .i_map_x      (i_map_x),
        .i_map_y      (i_map_y),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_valid      (o_valid),
        .o_pixel_out  (o_pixel_out)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatch_cnt++;
    endtask

    // check each result word against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch($sformatf("pixel %0d with none expected", o_pixel_out));
            end else begin
                oldest = expected_pixels.pop_front();
                if (o_pixel_out !== oldest.pixel)
                    report_mismatch($sformatf("x=%h y=%h pixel %0d, expected %0d",
                        oldest.mx, oldest.my, o_pixel_out, oldest.pixel));
            end
        end
    end

    function automatic int eff_w();
        return (int'(sim_w) > MAXW) ? MAXW : int'(sim_w);
    endfunction

    function automatic int eff_h();
        return (int'(sim_h) > MAXH) ? MAXH : int'(sim_h);
    endfunction

    function automatic bit in_frame(int col, int row);
        return col >= 0 && row >= 0 && col < eff_w() && row < eff_h();
    endfunction

    function automatic int stored_px(int col, int row);
        if (!in_frame(col, row))
            return 0;
        return int'(frame_copy[row * MAXW + col]);
    endfunction

    function automatic bit px_ready(int col, int row);
        return !in_frame(col, row) || frame_loaded[row * MAXW + col];
    endfunction

    function automatic logic [PIX_W-1:0] warp_pixel(logic [COORD_W-1:0] mx,
                                                    logic [COORD_W-1:0] my);
        int x, y, x0, y0, wx, wy, acc;
        x = int'($signed(mx));
        y = int'($signed(my));
        if (x < 0)
            return '0;
        if (sim_mode == INTERP_NEAREST)
            return PIX_W'(stored_px((x + ONE / 2) >>> FRAC, (y + ONE / 2) >>> FRAC));
        x0 = x >>> FRAC;
        y0 = y >>> FRAC;
        wx = x & (ONE - 1);
        wy = y & (ONE - 1);
        acc = (ONE - wx) * ((ONE - wy) * stored_px(x0, y0) + wy * stored_px(x0, y0 + 1))
            + wx * ((ONE - wy) * stored_px(x0 + 1, y0) + wy * stored_px(x0 + 1, y0 + 1));
        acc = acc >> (2 * FRAC);
        return (acc > 255) ? PIX_W'(255) : PIX_W'(acc);
    endfunction

    function automatic bit reads_loaded(logic [COORD_W-1:0] mx, logic [COORD_W-1:0] my);
        int x, y, x0, y0;
        x = int'($signed(mx));
        y = int'($signed(my));
        if (x < 0)
            return 1'b1;
        if (sim_mode == INTERP_NEAREST)
            return px_ready((x + ONE / 2) >>> FRAC, (y + ONE / 2) >>> FRAC);
        x0 = x >>> FRAC;
        y0 = y >>> FRAC;
        return px_ready(x0, y0) && px_ready(x0 + 1, y0)
            && px_ready(x0, y0 + 1) && px_ready(x0 + 1, y0 + 1);
    endfunction

    function automatic logic [COORD_W-1:0] rand_coord(int extent);
        int v;
        case ($urandom_range(0, 9))
            0: return COORD_W'($urandom);
            1, 2: v = (extent - 1) * ONE + int'($urandom_range(0, 4 * ONE)) - 2 * ONE;
            default: v = int'($urandom_range(0, 20 * ONE)) - 2 * ONE;
        endcase
        return COORD_W'(v);
    endfunction

    function automatic logic [PIX_W-1:0] rand_pix();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    task automatic send_word(t_action act, logic [LOAD_W-1:0] col, logic [LOAD_W-1:0] row,
                             logic [PIX_W-1:0] pix, logic [COORD_W-1:0] mx,
                             logic [COORD_W-1:0] my);
        t_pixel_expect e;
        start        <= 1'b1;
        i_action     <= act;
        i_load_col   <= col;
        i_load_row   <= row;
        i_load_pixel <= pix;
        i_map_x      <= mx;
        i_map_y      <= my;
        do @(posedge i_clk); while (busy !== 1'b0);
        if (act == ACT_LOAD) begin
            frame_copy[int'(row) * MAXW + int'(col)]   = pix;
            frame_loaded[int'(row) * MAXW + int'(col)] = 1'b1;
        end else begin
            e.pixel = warp_pixel(mx, my);
            e.mx    = mx;
            e.my    = my;
            expected_pixels.push_back(e);
        end
    endtask

    task automatic load_px(logic [LOAD_W-1:0] col, logic [LOAD_W-1:0] row,
                           logic [PIX_W-1:0] pix);
        send_word(ACT_LOAD, col, row, pix, COORD_W'($urandom), COORD_W'($urandom));
    endtask

    task automatic sample_at(logic [COORD_W-1:0] mx, logic [COORD_W-1:0] my);
        send_word(ACT_SAMPLE, LOAD_W'($urandom), LOAD_W'($urandom), PIX_W'($urandom), mx, my);
    endtask

    task automatic idle_gap(bit steady);
        int n;
        n = 0;
        if (!steady) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: n = 0;
                5, 6, 7, 8: n = $urandom_range(1, 3);
                default: n = $urandom_range(5, 40);
            endcase
        end
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // hold off until every predicted pixel is back and loads have drained
    task automatic settle();
        start <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_reg idx, logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        case (idx)
            CFG_INTERP_MODE:  sim_mode = t_interp'(data[0]);
            CFG_FRAME_WIDTH:  sim_w = data;
            CFG_FRAME_HEIGHT: sim_h = data;
            default: ;
        endcase
    endtask

    task automatic apply_settings(t_interp mode, int w, int h);
        settle();
        cfg_write(CFG_INTERP_MODE, {(CFG_W-1)'($urandom), mode});
        cfg_write(CFG_FRAME_WIDTH, CFG_W'(w));
        cfg_write(CFG_FRAME_HEIGHT, CFG_W'(h));
        i_cfg_we <= 1'b0;
    endtask

    // reset settings: bilinear over the full 512 x 512 frame
    task automatic test_directed_bilinear();
        load_px(LOAD_W'(0), LOAD_W'(0), 8'hFF);
        load_px(LOAD_W'(1), LOAD_W'(0), 8'hFF);
        load_px(LOAD_W'(0), LOAD_W'(1), 8'hFF);
        load_px(LOAD_W'(1), LOAD_W'(1), 8'hFF);
        load_px(LOAD_W'(511), LOAD_W'(511), 8'hA5);
        load_px(LOAD_W'(510), LOAD_W'(511), 8'h5A);
        load_px(LOAD_W'(511), LOAD_W'(510), 8'hFF);
        load_px(LOAD_W'(510), LOAD_W'(510), 8'h00);
        sample_at(COORD_W'(0), COORD_W'(0));
        sample_at(COORD_W'(ONE - 1), COORD_W'(ONE - 1));
        sample_at(COORD_W'(131071), COORD_W'(131071));
        sample_at(COORD_W'(510 * ONE + ONE / 2), COORD_W'(510 * ONE + ONE / 2));
        sample_at(COORD_W'(-131072), COORD_W'(0));
        sample_at(COORD_W'(0), COORD_W'(-1));
    endtask

    // half-up rounding, top edge, negative x and the row above the frame
    task automatic test_directed_nearest();
        apply_settings(INTERP_NEAREST, MAXW, MAXH);
        sample_at(COORD_W'(ONE / 2 - 1), COORD_W'(ONE / 2 - 1));
        sample_at(COORD_W'(ONE / 2), COORD_W'(ONE / 2));
        sample_at(COORD_W'(131071), COORD_W'(131071));
        sample_at(COORD_W'(-1), COORD_W'(0));
        sample_at(COORD_W'(0), COORD_W'(-ONE / 2));
        sample_at(COORD_W'(0), COORD_W'(-ONE / 2 - 1));
    endtask

    task automatic test_fill_region();
        for (int r = 0; r < 16; r++)
            for (int c = 0; c < 16; c++) begin
                load_px(LOAD_W'(c), LOAD_W'(r), rand_pix());
                idle_gap(1'b0);
            end
    endtask

    task automatic test_random_phases();
        t_interp          m;
        int               w, h, tries;
        bit               steady;
        logic [COORD_W-1:0] mx, my;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0:  begin m = INTERP_BILINEAR; w = 512;  h = 512;  end
                1:  begin m = INTERP_NEAREST;  w = 512;  h = 512;  end
                2:  begin m = INTERP_BILINEAR; w = 16;   h = 16;   end
                3:  begin m = INTERP_NEAREST;  w = 16;   h = 16;   end
                4:  begin m = INTERP_BILINEAR; w = 1;    h = 1;    end
                5:  begin m = INTERP_NEAREST;  w = 0;    h = 0;    end
                6:  begin m = INTERP_BILINEAR; w = 0;    h = 9;    end
                7:  begin m = INTERP_BILINEAR; w = 1023; h = 1023; end
                8:  begin m = INTERP_NEAREST;  w = 600;  h = 1023; end
                9:  begin m = INTERP_BILINEAR; w = 12;   h = 5;    end
                10: begin m = INTERP_NEAREST;  w = 3;    h = 17;   end
                11: begin m = INTERP_BILINEAR; w = 512;  h = 1;    end
                default: begin
                    m = t_interp'($urandom_range(0, 1));
                    w = $urandom_range(1, 18);
                    h = $urandom_range(1, 18);
                end
            endcase
            apply_settings(m, w, h);
            steady = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if ($urandom_range(0, 99) < 35) begin
                    if ($urandom_range(0, 9) < 7)
                        load_px(LOAD_W'($urandom_range(0, 15)), LOAD_W'($urandom_range(0, 15)),
                                rand_pix());
                    else
                        load_px(LOAD_W'($urandom), LOAD_W'($urandom), rand_pix());
                end else begin
                    tries = 0;
                    do begin
                        mx = rand_coord(eff_w());
                        my = rand_coord(eff_h());
                        tries++;
                    end while (!reads_loaded(mx, my) && tries < 40);
                    if (!reads_loaded(mx, my))
                        mx = {1'b1, (COORD_W-1)'($urandom)};
                    sample_at(mx, my);
                end
                idle_gap(steady);
                if (ph % 4 == 1 && n == PHASE_WORDS / 2)
                    settle();
            end
        end
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_action     <= ACT_LOAD;
        i_load_col   <= '0;
        i_load_row   <= '0;
        i_load_pixel <= '0;
        i_map_x      <= '0;
        i_map_y      <= '0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= CFG_INTERP_MODE;
        i_cfg_wdata  <= '0;
        sim_mode = INTERP_BILINEAR;
        sim_w    = RST_FRAME_WIDTH;
        sim_h    = RST_FRAME_HEIGHT;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_bilinear();
        test_directed_nearest();
        test_fill_region();
        test_random_phases();

        settle();
        if (expected_pixels.size() != 0)
            report_mismatch($sformatf("%0d pixels never returned", expected_pixels.size()));
        if (mismatch_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
